// ----- hw/rtl/fdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared types and fp32 arithmetic helpers for the fp16 dot / distance block.
// ----------------------------------------------------------------------------
package fdsd_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF   = 32'h7F80_0000;

	// operation selected by the mode register
	typedef enum logic {
		MODE_DOT  = 1'b0,
		MODE_DIST = 1'b1
	} mode_t;

	// unrounded result: value = sig * 2^k, unless special or zero
	typedef struct packed {
		logic               special;
		logic [31:0]        special_bits;
		logic               zero;
		logic               sign;
		logic signed [11:0] k;
		logic [50:0]        sig;
	} fp_pre_t;

	// one product term waiting for the accumulator
	typedef struct packed {
		logic [31:0] term;
		logic        last;
	} term_t;

	// exact widening of half to single
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  ex;
		logic [10:0] man;
		logic [7:0]  e32;
		logic [31:0] res;
		ex  = h[14:10];
		man = {1'b0, h[9:0]};
		e32 = 8'd0;
		res = 32'd0;
		if (ex == 5'd31) begin
			res = (man == 11'd0) ? {h[15], POS_INF[30:0]} : CANON_NAN;
		end else if (ex == 5'd0) begin
			if (man == 11'd0) begin
				res = {h[15], 31'd0};
			end else begin
				e32 = 8'd113;
				for (int i = 0; i < 10; i++) begin
					if (man[10] == 1'b0) begin
						man = {man[9:0], 1'b0};
						e32 = e32 - 8'd1;
					end
				end
				res = {h[15], e32, man[9:0], 13'd0};
			end
		end else begin
			res = {h[15], 8'({3'd0, ex} + 8'd112), h[9:0], 13'd0};
		end
		return res;
	endfunction

	// align and add, no rounding yet
	function automatic fp_pre_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
		fp_pre_t     r;
		logic        a_nan, b_nan, a_inf, b_inf, swap, lost;
		logic [31:0] big, sml;
		logic [7:0]  e_big, e_sml, d;
		logic [49:0] big_x, sml_x, sml_sh;
		logic [50:0] sum;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		swap  = b[30:0] > a[30:0];
		big   = swap ? b : a;
		sml   = swap ? a : b;
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d     = e_big - e_sml;
		big_x = {(big[30:23] != 8'd0), big[22:0], 26'd0};
		sml_x = {(sml[30:23] != 8'd0), sml[22:0], 26'd0};
		if (d >= 8'd50) begin
			sml_sh = 50'd0;
			lost   = (sml_x != 50'd0);
		end else begin
			sml_sh = sml_x >> d;
			lost   = ((sml_sh << d) != sml_x);
		end
		sml_sh[0] = sml_sh[0] | lost;
		if (a[31] ^ b[31])
			sum = {1'b0, big_x} - {1'b0, sml_sh};
		else
			sum = {1'b0, big_x} + {1'b0, sml_sh};
		r.special      = 1'b0;
		r.special_bits = CANON_NAN;
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			r.special = 1'b1;
		end else if (a_inf || b_inf) begin
			r.special      = 1'b1;
			r.special_bits = {(a_inf ? a[31] : b[31]), POS_INF[30:0]};
		end
		r.sig  = sum;
		r.zero = (sum == 51'd0);
		r.sign = r.zero ? (a[31] & b[31]) : big[31];
		r.k    = 12'($signed({4'd0, e_big}) - 12'sd176);
		return r;
	endfunction

	// full product, no rounding yet
	function automatic fp_pre_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
		fp_pre_t     r;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		logic [47:0] prod;
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		r.special      = 1'b0;
		r.special_bits = CANON_NAN;
		r.sign         = a[31] ^ b[31];
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			r.special = 1'b1;
		end else if (a_inf || b_inf) begin
			r.special      = 1'b1;
			r.special_bits = {r.sign, POS_INF[30:0]};
		end
		r.zero = a_zero || b_zero;
		ma     = {(a[30:23] != 8'd0), a[22:0]};
		mb     = {(b[30:23] != 8'd0), b[22:0]};
		prod   = {24'd0, ma} * {24'd0, mb};
		r.sig  = {3'd0, prod};
		r.k    = 12'($signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd300);
		return r;
	endfunction

	// normalize and round to nearest even
	function automatic logic [31:0] fp_round(input fp_pre_t p);
		logic [5:0]         lead, shv;
		logic signed [11:0] e_unb, biased, lsb;
		logic [63:0]        ext, kept64, mask;
		logic [23:0]        kept;
		logic [7:0]         exp_f;
		logic               rb, st;
		logic [30:0]        pack;
		logic [31:0]        res;
		lead = 6'd0;
		for (int i = 0; i < 51; i++) begin
			if (p.sig[i])
				lead = 6'(i);
		end
		e_unb  = 12'($signed({6'd0, lead}) + p.k);
		biased = e_unb + 12'sd127;
		if (biased >= 12'sd1) begin
			lsb   = 12'($signed({6'd0, lead}) - 12'sd23);
			exp_f = biased[7:0];
		end else begin
			lsb   = 12'(-12'sd149 - p.k);
			exp_f = 8'd0;
		end
		ext  = {13'd0, p.sig};
		kept = 24'd0;
		rb   = 1'b0;
		st   = 1'b0;
		shv  = 6'd0;
		mask = 64'd0;
		kept64 = 64'd0;
		if (lsb <= 12'sd0) begin
			kept64 = ext << 6'(-lsb);
			kept   = kept64[23:0];
		end else begin
			shv    = (lsb > 12'sd52) ? 6'd52 : lsb[5:0];
			kept64 = ext >> shv;
			kept   = kept64[23:0];
			rb     = ext[shv - 6'd1];
			mask   = (64'd1 << (shv - 6'd1)) - 64'd1;
			st     = |(ext & mask);
		end
		pack = {exp_f, kept[22:0]} + {30'd0, rb & (st | kept[0])};
		if (p.special)
			res = p.special_bits;
		else if (p.zero)
			res = {p.sign, 31'd0};
		else if (biased >= 12'sd255)
			res = {p.sign, POS_INF[30:0]};
		else
			res = {p.sign, pack};
		return res;
	endfunction

endpackage

// ----- hw/rtl/fdsd_front.sv -----
// ----------------------------------------------------------------------------
// fdsd_front
// Widens the fp16 pair and forms the product term in a five stage pipeline.
// ----------------------------------------------------------------------------
module fdsd_front import fdsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [15:0] a_value,
	input  logic [15:0] b_value,
	input  logic        last,
	input  mode_t       mode,
	output logic        term_valid,
	output term_t       term_out
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        last_s1, last_s2, last_s3, last_s4;
	mode_t       mode_s1, mode_s2;
	logic [31:0] x_s1, y_s1, x_s2, y_s2;
	fp_pre_t     sub_s2, mul_s4;
	logic [31:0] opa_s3, opb_s3;
	term_t       term_s5;
	logic [31:0] diff;

	assign diff = fp_round(sub_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= half_to_single(a_value);
		y_s1    <= half_to_single(b_value);
		last_s1 <= last;
		mode_s1 <= mode;
		// subtract as add with b negated
		sub_s2  <= fp_add_pre(x_s1, {~y_s1[31], y_s1[30:0]});
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;
		opa_s3  <= (mode_s2 == MODE_DIST) ? diff : x_s2;
		opb_s3  <= (mode_s2 == MODE_DIST) ? diff : y_s2;
		last_s3 <= last_s2;
		mul_s4  <= fp_mul_pre(opa_s3, opb_s3);
		last_s4 <= last_s3;
		term_s5 <= '{term: fp_round(mul_s4), last: last_s4};
	end

	assign term_valid = valid_s5;
	assign term_out   = term_s5;

endmodule

// ----- hw/rtl/fdsd_queue.sv -----
// ----------------------------------------------------------------------------
// fdsd_queue
// Small FIFO of product terms between the front pipeline and the accumulator.
// ----------------------------------------------------------------------------
module fdsd_queue import fdsd_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  term_t push_data,
	input  logic  pop,
	output logic  head_valid,
	output term_t head_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	term_t           mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = mem[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (count_q == CW'(DEPTH))))
		else $error("term queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("term queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("term queue count out of range");

endmodule

// ----- hw/rtl/fdsd_back.sv -----
// ----------------------------------------------------------------------------
// fdsd_back
// Running fp32 accumulator with a registered result slot.
// ----------------------------------------------------------------------------
module fdsd_back import fdsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  term_t       head_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sum_bits
);

	logic        busy_q, last_q, out_valid_q;
	fp_pre_t     add_pre_q;
	logic [31:0] acc_q, sum_q, acc_next;

	// a closing term only starts once the result slot is free
	assign pop      = head_valid && !busy_q && (!head_data.last || !out_valid_q);
	assign acc_next = fp_round(add_pre_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= 32'd0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				busy_q <= 1'b1;
				last_q <= head_data.last;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				if (last_q) begin
					out_valid_q <= 1'b1;
					acc_q       <= 32'd0;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			add_pre_q <= fp_add_pre(acc_q, head_data.term);
		if (busy_q && last_q)
			sum_q <= acc_next;
	end

	assign out_valid = out_valid_q;
	assign sum_bits  = sum_q;

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && last_q |-> !out_valid_q)
		else $error("result slot busy when closing a vector");
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("accumulate step longer than two cycles");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && last_q |=> acc_q == 32'd0 && out_valid_q)
		else $error("accumulator not cleared after last term");

endmodule

// ----- hw/rtl/fp16_dot_or_squared_distance_top.sv -----
// Streams pairs of fp16 elements and returns an fp32 dot product (mode 0) or
// squared euclidean distance (mode 1) on the pair marked last, rounding each
// subtract, multiply and add to nearest even in fp32 in stream order, with
// subnormals kept and any NaN returned as 0x7FC00000. A pair is taken every
// cycle while the term queue has room, and enters the front pipeline. The
// accumulator loop sets the sustained rate: it takes a new term only once the
// previous one is through (align/add, then normalize/round in the next). A
// result waits in an output register.
// ----------------------------------------------------------------------------
// fp16_dot_or_squared_distance_top
// Top level: config register, front pipeline, term queue and accumulator.
// ----------------------------------------------------------------------------
module fp16_dot_or_squared_distance_top import fdsd_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mode_wr_en,
	input  logic        mode_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] a_value,
	input  logic [15:0] b_value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sum_bits
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	mode_t         mode_q;
	logic [CW-1:0] inflight_q;
	logic          in_fire, term_valid, head_valid, pop;
	term_t         term, head;

	assign in_fire  = in_valid && in_ready;
	// credit: every accepted pair has a queue slot reserved
	assign in_ready = (inflight_q < CW'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DOT;
			inflight_q <= '0;
		end else begin
			if (mode_wr_en)
				mode_q <= mode_t'(mode_wr_data);
			if (in_fire && !pop)
				inflight_q <= inflight_q + CW'(1);
			else if (pop && !in_fire)
				inflight_q <= inflight_q - CW'(1);
		end
	end

	fdsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.a_value    (a_value),
		.b_value    (b_value),
		.last       (last),
		.mode       (mode_q),
		.term_valid (term_valid),
		.term_out   (term)
	);

	fdsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (term_valid),
		.push_data  (term),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head)
	);

	fdsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sum_bits   (sum_bits)
	);

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(QUEUE_DEPTH))
		else $error("more pairs in flight than queue slots");
	a_pop_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> inflight_q != '0)
		else $error("term popped with no pair in flight");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !head_valid)
		else $error("queue holds a term with no pair in flight");

endmodule
